>>> design/cll_pkg.sv
// Shared constants for the cursor linked list engine: field widths,
// operation and status codes, and the default node store size.
// No dependencies.
`timescale 1ns / 1ps

package cll_pkg;

  // Default number of nodes in the store
  localparam int unsigned CLL_CAPACITY = 16;

  // Request and response field widths
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned VALUE_W  = 8;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = 11;

  // Stream widths; the data widths are padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned IN_TUSER_W  = OPCODE_W;
  localparam int unsigned OUT_TDATA_W = 40;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SEARCH  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DEL_ALL = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

>>> design/cll_ram.sv
// Simple dual-port node store: one write port and one read port with
// registered read data. Uses cll_pkg for defaults.
`timescale 1ns / 1ps

module cll_ram #(
  parameter int unsigned DEPTH = cll_pkg::CLL_CAPACITY,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on enable, register the read word every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/cursor_linked_list_engine.sv
// Cursor linked list engine: doubly linked byte list in a node store with a free list.
// One request at a time; each walk follows one link per cycle through one read address,
// pausing to apply the link fixes after each node that delete-all removes.
// Reset: a pass over every node chains the free list in the next-link memory; no
// request is accepted until it ends. Depends on cll_pkg and cll_ram.
`timescale 1ns / 1ps

module cursor_linked_list_engine #(
  parameter int unsigned CAPACITY = cll_pkg::CLL_CAPACITY
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [7:0] value, [18:8] position, [23:19] zero
  input  logic [cll_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // [2:0] opcode
  input  logic [cll_pkg::IN_TUSER_W-1:0]   s_axis_tuser_i,
  // Response stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [1:0] status, [12:2] found_position, [23:13] removed_count,
  // [34:24] length, [39:35] zero
  output logic [cll_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);

  import cll_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned LW = IW + 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL    = '1;
  localparam logic [LW-1:0] CAP_L  = LW'(CAPACITY);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_I = IW'(CAPACITY - 1);

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_INS_FREE,
    S_INS_WALK,
    S_DEL_WALK,
    S_SRCH,
    S_DALL,
    S_FIX,
    S_RESP
  } state_e;

  function automatic logic is_node(input logic [LW-1:0] x);
    return x < CAP_L;
  endfunction

  // Control and list registers
  state_e                state_q, state_d;
  logic                  init_q, init_d;
  logic [IW-1:0]         sweep_q, sweep_d;
  logic [LW-1:0]         head_q, head_d;
  logic [LW-1:0]         tail_q, tail_d;
  logic [LW-1:0]         free_q, free_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  // Request and walk registers
  logic [OPCODE_W-1:0]   op_q, op_d;
  logic [VALUE_W-1:0]    val_q, val_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [LW-1:0]         cur_q, cur_d;
  logic [LW-1:0]         n_q, n_d;
  logic [CW-1:0]         steps_q, steps_d;
  logic [CW-1:0]         rank_q, rank_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [CW-1:0]         found_q, found_d;
  logic [CW-1:0]         removed_q, removed_d;

  // Deferred link writes
  logic                  fn_en_q, fn_en_d;
  logic [IW-1:0]         fn_addr_q, fn_addr_d;
  logic [LW-1:0]         fn_val_q, fn_val_d;
  logic                  fp_en_q, fp_en_d;
  logic [IW-1:0]         fp_addr_q, fp_addr_d;
  logic [LW-1:0]         fp_val_q, fp_val_d;

  // Node memory ports
  logic                  val_we, nxt_we, prv_we;
  logic [IW-1:0]         val_waddr, nxt_waddr, prv_waddr, raddr;
  logic [VALUE_W-1:0]    val_wdata, val_rd;
  logic [LW-1:0]         nxt_wdata, prv_wdata, nxt_rd, prv_rd;

  logic                  accept;
  logic                  do_unlink;
  logic [POS_W-1:0]      count_p;
  logic [POS_W-1:0]      in_pos;
  logic [VALUE_W-1:0]    in_val;
  logic [OPCODE_W-1:0]   in_op;

  assign in_val  = s_axis_tdata_i[VALUE_W-1:0];
  assign in_pos  = s_axis_tdata_i[VALUE_W +: POS_W];
  assign in_op   = s_axis_tuser_i;
  assign count_p = POS_W'(count_q);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Node value, next link and previous link, read at one shared address
  cll_ram #(.DEPTH(CAPACITY), .WIDTH(VALUE_W)) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(val_wdata),
    .raddr_i(raddr),
    .rdata_o(val_rd)
  );

  cll_ram #(.DEPTH(CAPACITY), .WIDTH(LW)) u_nxt_ram (
    .clk_i  (clk_i),
    .we_i   (nxt_we),
    .waddr_i(nxt_waddr),
    .wdata_i(nxt_wdata),
    .raddr_i(raddr),
    .rdata_o(nxt_rd)
  );

  cll_ram #(.DEPTH(CAPACITY), .WIDTH(LW)) u_prv_ram (
    .clk_i  (clk_i),
    .we_i   (prv_we),
    .waddr_i(prv_waddr),
    .wdata_i(prv_wdata),
    .raddr_i(raddr),
    .rdata_o(prv_rd)
  );

  // Sequencer: next state, list updates and memory writes
  always_comb begin
    state_d   = state_q;
    init_d    = init_q;
    sweep_d   = sweep_q;
    head_d    = head_q;
    tail_d    = tail_q;
    free_d    = free_q;
    count_d   = count_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    op_d      = op_q;
    val_d     = val_q;
    pos_d     = pos_q;
    cur_d     = cur_q;
    n_d       = n_q;
    steps_d   = steps_q;
    rank_d    = rank_q;
    status_d  = status_q;
    found_d   = found_q;
    removed_d = removed_q;
    fn_en_d   = fn_en_q;
    fn_addr_d = fn_addr_q;
    fn_val_d  = fn_val_q;
    fp_en_d   = fp_en_q;
    fp_addr_d = fp_addr_q;
    fp_val_d  = fp_val_q;
    val_we    = 1'b0;
    val_waddr = '0;
    val_wdata = '0;
    nxt_we    = 1'b0;
    nxt_waddr = '0;
    nxt_wdata = '0;
    prv_we    = 1'b0;
    prv_waddr = '0;
    prv_wdata = '0;
    do_unlink = 1'b0;

    // Drop the response once taken
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_SWEEP: begin
        // Chain node i to i+1, last node to null
        nxt_we    = 1'b1;
        nxt_waddr = sweep_q;
        if (sweep_q == LAST_I) begin
          nxt_wdata = NIL;
          init_d    = 1'b0;
          state_d   = init_q ? S_IDLE : S_RESP;
        end else begin
          nxt_wdata = {1'b0, sweep_q} + LW'(1);
          sweep_d   = sweep_q + IW'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          op_d      = in_op;
          val_d     = in_val;
          pos_d     = in_pos;
          status_d  = ST_OK;
          found_d   = '0;
          removed_d = '0;
          case (in_op)
            OP_INSERT: begin
              if (!is_node(free_q)) begin
                status_d = ST_FULL;
                state_d  = S_RESP;
              end else begin
                cur_d   = free_q;
                n_d     = free_q;
                state_d = S_INS_FREE;
              end
            end
            OP_DELETE: begin
              if (in_pos == '0 || in_pos > count_p) begin
                status_d = ST_BAD_POS;
                state_d  = S_RESP;
              end else begin
                cur_d   = head_q;
                steps_d = CW'(in_pos - POS_W'(1));
                state_d = S_DEL_WALK;
              end
            end
            OP_SEARCH: begin
              cur_d   = head_q;
              rank_d  = CW'(1);
              state_d = S_SRCH;
            end
            OP_DEL_ALL: begin
              cur_d   = head_q;
              state_d = S_DALL;
            end
            OP_CLEAR: begin
              removed_d = count_q;
              head_d    = NIL;
              tail_d    = NIL;
              free_d    = '0;
              count_d   = '0;
              sweep_d   = '0;
              state_d   = S_SWEEP;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_INS_FREE: begin
        // Pop the free node and store its value
        free_d    = nxt_rd;
        count_d   = count_q + CW'(1);
        val_we    = 1'b1;
        val_waddr = n_q[IW-1:0];
        val_wdata = val_q;
        if (pos_q > count_p) begin
          // Append after the tail
          prv_we    = 1'b1;
          prv_waddr = n_q[IW-1:0];
          prv_wdata = tail_q;
          nxt_we    = 1'b1;
          nxt_waddr = n_q[IW-1:0];
          nxt_wdata = NIL;
          fn_en_d   = is_node(tail_q);
          fn_addr_d = tail_q[IW-1:0];
          fn_val_d  = n_q;
          fp_en_d   = 1'b0;
          if (!is_node(tail_q)) begin
            head_d = n_q;
          end
          tail_d  = n_q;
          state_d = S_FIX;
        end else if (pos_q <= POS_W'(1)) begin
          // Push in front of the head
          prv_we    = 1'b1;
          prv_waddr = n_q[IW-1:0];
          prv_wdata = NIL;
          nxt_we    = 1'b1;
          nxt_waddr = n_q[IW-1:0];
          nxt_wdata = head_q;
          fp_en_d   = is_node(head_q);
          fp_addr_d = head_q[IW-1:0];
          fp_val_d  = n_q;
          fn_en_d   = 1'b0;
          if (!is_node(head_q)) begin
            tail_d = n_q;
          end
          head_d  = n_q;
          state_d = S_FIX;
        end else begin
          cur_d   = head_q;
          steps_d = CW'(pos_q - POS_W'(1));
          state_d = S_INS_WALK;
        end
      end

      S_INS_WALK: begin
        if (steps_q == '0) begin
          // Splice the new node before the target
          nxt_we    = 1'b1;
          nxt_waddr = n_q[IW-1:0];
          nxt_wdata = cur_q;
          prv_we    = 1'b1;
          prv_waddr = cur_q[IW-1:0];
          prv_wdata = n_q;
          fn_en_d   = 1'b1;
          fn_addr_d = prv_rd[IW-1:0];
          fn_val_d  = n_q;
          fp_en_d   = 1'b1;
          fp_addr_d = n_q[IW-1:0];
          fp_val_d  = prv_rd;
          state_d   = S_FIX;
        end else begin
          cur_d   = nxt_rd;
          steps_d = steps_q - CW'(1);
        end
      end

      S_DEL_WALK: begin
        if (steps_q == '0) begin
          do_unlink = 1'b1;
          removed_d = CW'(1);
          state_d   = S_FIX;
        end else begin
          cur_d   = nxt_rd;
          steps_d = steps_q - CW'(1);
        end
      end

      S_SRCH: begin
        if (!is_node(cur_q)) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_RESP;
        end else if (val_rd == val_q) begin
          found_d = rank_q;
          state_d = S_RESP;
        end else begin
          cur_d  = nxt_rd;
          rank_d = rank_q + CW'(1);
        end
      end

      S_DALL: begin
        if (!is_node(cur_q)) begin
          if (removed_q == '0) begin
            status_d = ST_NOT_FOUND;
          end
          state_d = S_RESP;
        end else begin
          cur_d = nxt_rd;
          if (val_rd == val_q) begin
            // Unlink, then reread the successor after its prev link settles
            do_unlink = 1'b1;
            removed_d = removed_q + CW'(1);
            state_d   = S_FIX;
          end
        end
      end

      S_FIX: begin
        // Apply the deferred link writes
        nxt_we    = fn_en_q;
        nxt_waddr = fn_addr_q;
        nxt_wdata = fn_val_q;
        prv_we    = fp_en_q;
        prv_waddr = fp_addr_q;
        prv_wdata = fp_val_q;
        state_d   = (op_q == OP_DEL_ALL) ? S_DALL : S_RESP;
      end

      S_RESP: begin
        // Hand the response to the output register when it is free
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_TDATA_W'({CNT_W'(count_q), CNT_W'(removed_q),
                                    CNT_W'(found_q), status_q});
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Unlink the current node and return it to the free list
    if (do_unlink) begin
      nxt_we    = 1'b1;
      nxt_waddr = cur_q[IW-1:0];
      nxt_wdata = free_q;
      free_d    = cur_q;
      count_d   = count_q - CW'(1);
      if (is_node(nxt_rd)) begin
        prv_we    = 1'b1;
        prv_waddr = nxt_rd[IW-1:0];
        prv_wdata = prv_rd;
      end else begin
        tail_d = prv_rd;
      end
      fn_en_d   = is_node(prv_rd);
      fn_addr_d = prv_rd[IW-1:0];
      fn_val_d  = nxt_rd;
      fp_en_d   = 1'b0;
      if (!is_node(prv_rd)) begin
        head_d = nxt_rd;
      end
    end
  end

  // Read the node that the cursor moves to
  assign raddr = cur_d[IW-1:0];

  // State, list registers and response valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_SWEEP;
      init_q    <= 1'b1;
      sweep_q   <= '0;
      head_q    <= NIL;
      tail_q    <= NIL;
      free_q    <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      init_q    <= init_d;
      sweep_q   <= sweep_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      free_q    <= free_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Response data, request payload and walk registers
  always_ff @(posedge clk_i) begin
    m_data_q  <= m_data_d;
    op_q      <= op_d;
    val_q     <= val_d;
    pos_q     <= pos_d;
    cur_q     <= cur_d;
    n_q       <= n_d;
    steps_q   <= steps_d;
    rank_q    <= rank_d;
    status_q  <= status_d;
    found_q   <= found_d;
    removed_q <= removed_d;
    fn_en_q   <= fn_en_d;
    fn_addr_q <= fn_addr_d;
    fn_val_q  <= fn_val_d;
    fp_en_q   <= fp_en_d;
    fp_addr_q <= fp_addr_d;
    fp_val_q  <= fp_val_d;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("element count exceeds store size");

  a_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((count_q == '0) == !is_node(head_q)))
    else $error("head pointer disagrees with element count");

  a_tail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((count_q == '0) == !is_node(tail_q)))
    else $error("tail pointer disagrees with element count");

  a_free_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((count_q == CAP_C) == !is_node(free_q)))
    else $error("free list disagrees with element count");

  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && status_q == ST_FULL) |-> (op_q == OP_INSERT))
    else $error("store full status on a request other than insert");
`endif

endmodule

>>> verif/tb.sv
// Self-checking bench for cursor_linked_list_engine: directed list edge cases, then
// random traffic over every opcode with bursty requests and a stalling response side.
// Depends on cll_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb;
  import cll_pkg::*;

  localparam int unsigned CAPACITY     = CLL_CAPACITY;
  localparam int unsigned RANDOM_ITEMS = 1620;

  // One response beat, unpacked into its fields
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found_position;
    logic [CNT_W-1:0]    removed_count;
    logic [CNT_W-1:0]    length;
  } list_response_t;

  // Tracks list contents and the responses still owed by the engine
  class list_scoreboard;
    byte unsigned   contents[$];
    list_response_t owed_q[$];
    int unsigned    capacity;
    int unsigned    errors;
    int unsigned    requests_noted;
    int unsigned    responses_checked;
    int unsigned    longest_list;
    int unsigned    op_seen[8];
    int unsigned    status_seen[4];

    function new(int unsigned cap);
      capacity = cap;
    endfunction

    function int unsigned size();
      return contents.size();
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Apply an accepted request to the list and queue the response it owes
    function void note_request(logic [OPCODE_W-1:0] opcode, logic [VALUE_W-1:0] value,
                               logic [POS_W-1:0] position);
      list_response_t r;
      r = '0;
      r.status = ST_OK;
      case (opcode)
        OP_INSERT: begin
          if (contents.size() >= capacity) begin
            r.status = ST_FULL;
          end else if (position > contents.size()) begin
            contents.push_back(value);
          end else if (position <= 1) begin
            contents.push_front(value);
          end else begin
            contents.insert(position - 1, value);
          end
        end
        OP_DELETE: begin
          if (position == 0 || position > contents.size()) begin
            r.status = ST_BAD_POS;
          end else begin
            contents.delete(position - 1);
            r.removed_count = CNT_W'(1);
          end
        end
        OP_SEARCH: begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < contents.size(); i++) begin
            if (contents[i] == value) begin
              r.status = ST_OK;
              r.found_position = POS_W'(i + 1);
              break;
            end
          end
        end
        OP_DEL_ALL: begin
          for (int i = contents.size() - 1; i >= 0; i--) begin
            if (contents[i] == value) begin
              contents.delete(i);
              r.removed_count++;
            end
          end
          if (r.removed_count == 0) r.status = ST_NOT_FOUND;
        end
        OP_CLEAR: begin
          r.removed_count = CNT_W'(contents.size());
          contents.delete();
        end
        default: ;  // unused codes leave the list alone
      endcase
      r.length = CNT_W'(contents.size());
      if (contents.size() > longest_list) longest_list = contents.size();
      op_seen[opcode]++;
      requests_noted++;
      owed_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Check one accepted response beat against the oldest owed response
    function void check_response(logic [OUT_TDATA_W-1:0] beat);
      list_response_t want;
      list_response_t got;
      if (owed_q.size() == 0) begin
        $display("%0t: response with nothing owed, expected none actual %h", $time, beat);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      got.status         = beat[1:0];
      got.found_position = beat[12:2];
      got.removed_count  = beat[23:13];
      got.length         = beat[34:24];
      compare_field("status", want.status, got.status);
      compare_field("found_position", want.found_position, got.found_position);
      compare_field("removed_count", want.removed_count, got.removed_count);
      compare_field("length", want.length, got.length);
      status_seen[got.status]++;
      responses_checked++;
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic [IN_TUSER_W-1:0]  s_axis_tuser_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  list_scoreboard board;
  int unsigned    burst_left;

  cursor_linked_list_engine uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Offer one request, inserting a random gap between bursts, and hold until taken
  task automatic send_request(logic [OPCODE_W-1:0] opcode, logic [VALUE_W-1:0] value,
                              logic [POS_W-1:0] position);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_TDATA_W - VALUE_W - POS_W){1'b0}}, position, value};
    s_axis_tuser_i  <= opcode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_request(opcode, value, position);
  endtask

  // Insert with a random value somewhere in or just past the list
  task automatic insert_anywhere();
    send_request(OP_INSERT, VALUE_W'($urandom_range(0, 255)),
                 POS_W'($urandom_range(0, board.size() + 1)));
  endtask

  // Request stream: reset, directed cases, then random traffic
  initial begin : request_source
    int unsigned pick;
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    position;
    bit grow;

    board = new(CAPACITY);
    burst_left = 0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty list: search and delete-all miss
    send_request(OP_SEARCH, 8'h5A, 11'd0);
    send_request(OP_DEL_ALL, 8'h5A, 11'd0);
    // Front insert at position zero, append past the end, middle and head inserts
    send_request(OP_INSERT, 8'h00, 11'd0);
    send_request(OP_INSERT, 8'hFF, 11'h7FF);
    send_request(OP_INSERT, 8'h5A, 11'd2);
    send_request(OP_INSERT, 8'h5A, 11'd1);
    send_request(OP_SEARCH, 8'h5A, 11'd0);
    // Delete out of range on both sides, then a valid one
    send_request(OP_DELETE, 8'h00, 11'd0);
    send_request(OP_DELETE, 8'h00, 11'd5);
    send_request(OP_DELETE, 8'h00, 11'd2);
    send_request(OP_DEL_ALL, 8'h5A, 11'd0);
    send_request(OP_CLEAR + 3'd3, 8'hC3, 11'd3);
    // Fill the store, overflow it once, then clear it
    while (board.size() < CAPACITY) insert_anywhere();
    insert_anywhere();
    send_request(OP_CLEAR, 8'h00, 11'd0);

    // Random traffic in alternating grow and shrink phases
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      grow = ((n / 120) % 2) == 0;
      pick = $urandom_range(0, 99);
      if (grow) begin
        opcode = OPCODE_W'(pick < 60 ? OP_INSERT : pick < 72 ? OP_DELETE :
                           pick < 87 ? OP_SEARCH : pick < 95 ? OP_DEL_ALL :
                           pick < 97 ? OP_CLEAR : OP_CLEAR + $urandom_range(1, 3));
      end else begin
        opcode = OPCODE_W'(pick < 25 ? OP_INSERT : pick < 55 ? OP_DELETE :
                           pick < 75 ? OP_SEARCH : pick < 90 ? OP_DEL_ALL :
                           pick < 96 ? OP_CLEAR : OP_CLEAR + $urandom_range(1, 3));
      end
      // Mostly a small pool of values so searches hit and delete-all finds repeats
      value = VALUE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
                                                     $urandom_range(0, 5));
      pick = $urandom_range(0, 9);
      position = POS_W'(pick == 0 ? 0 :
                        pick == 1 ? $urandom_range(0, 2047) :
                                    $urandom_range(1, board.size() + 1));
      send_request(opcode, value, position);
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain, then allow the longest walk to settle
    while (board.pending() != 0) @(posedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);

    $display("Ran %0d requests (ins %0d, del %0d, search %0d, del-all %0d, clear %0d, unused %0d)",
             board.requests_noted, board.op_seen[OP_INSERT], board.op_seen[OP_DELETE],
             board.op_seen[OP_SEARCH], board.op_seen[OP_DEL_ALL], board.op_seen[OP_CLEAR],
             board.op_seen[5] + board.op_seen[6] + board.op_seen[7]);
    $display("Checked %0d responses: ok %0d, full %0d, bad pos %0d, not found %0d; longest %0d",
             board.responses_checked, board.status_seen[ST_OK], board.status_seen[ST_FULL],
             board.status_seen[ST_BAD_POS], board.status_seen[ST_NOT_FOUND], board.longest_list);
    if (board.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Response side: check accepted beats and stall on a rotating pattern
  initial begin : response_sink
    int unsigned stall_phase;
    int unsigned hold_left;
    bit          pressure_done;
    m_axis_tready_i <= 1'b0;
    stall_phase   = 0;
    hold_left     = 0;
    pressure_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) board.check_response(m_axis_tdata_o);
      // Hold off once for a long stretch so the request side backs up
      if (!pressure_done && board.requests_noted >= 400) begin
        hold_left     = 300;
        pressure_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        stall_phase = (stall_phase + 1) % 96;
        if (stall_phase < 24) begin
          m_axis_tready_i <= 1'b1;
        end else if (stall_phase < 64) begin
          m_axis_tready_i <= ($urandom_range(0, 2) != 0);
        end else begin
          m_axis_tready_i <= stall_phase[1];
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    #10_000_000;
    $display("tb failed");
    $finish;
  end

endmodule

>>> filelist.f
design/cll_pkg.sv
design/cll_ram.sv
design/cursor_linked_list_engine.sv
verif/tb.sv
